FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros check on the rising clock edge and are quiet while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold in the same cycle as the condition.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed");
// The property must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: src/sswa_pkg.sv
`default_nettype none

package sswa_pkg;

    // Fixed-point scale of the score.
    localparam int SCALE_SHIFT = 10;
    localparam int DEN_SHIFT   = SCALE_SHIFT + 1;

    // Datapath widths.
    localparam int WIN_W     = 5;
    localparam int WSQ_W     = 2 * WIN_W;
    localparam int MUL_W     = 33;
    localparam int DEN_W     = 64 - DEN_SHIFT;
    localparam int DVD_W     = 63;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int STEP_W    = 4;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_C1  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN = 2'd2;

    // Steps of the preparation sequence: a product issued in one step is
    // taken from the multiplier register in the following step.
    localparam logic [STEP_W-1:0] ST_WSQ     = 4'd0;
    localparam logic [STEP_W-1:0] ST_MXY     = 4'd1;
    localparam logic [STEP_W-1:0] ST_MXX     = 4'd2;
    localparam logic [STEP_W-1:0] ST_MYY     = 4'd3;
    localparam logic [STEP_W-1:0] ST_PRQ     = 4'd4;
    localparam logic [STEP_W-1:0] ST_PCQ     = 4'd5;
    localparam logic [STEP_W-1:0] ST_PXS     = 4'd6;
    localparam logic [STEP_W-1:0] ST_PXS_CAP = 4'd7;
    localparam logic [STEP_W-1:0] ST_TERMS   = 4'd8;
    localparam logic [STEP_W-1:0] ST_NUM     = 4'd9;
    localparam logic [STEP_W-1:0] ST_DEN     = 4'd10;
    localparam logic [STEP_W-1:0] ST_DEN_CAP = 4'd11;
    localparam logic [STEP_W-1:0] ST_SUM     = 4'd12;
    localparam logic [STEP_W-1:0] ST_MAG     = 4'd13;

    // Steps of the score squaring sequence: each partial product is taken
    // from the multiplier register in the step right after it is issued.
    localparam logic [STEP_W-1:0] SQ_LO     = 4'd0;
    localparam logic [STEP_W-1:0] SQ_LO_CAP = 4'd1;
    localparam logic [STEP_W-1:0] SQ_X      = 4'd2;
    localparam logic [STEP_W-1:0] SQ_X_CAP  = 4'd3;

    // Sequencer states.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_DSTART = 7'b0000100,
        S_DWAIT  = 7'b0001000,
        S_FIX    = 7'b0010000,
        S_SQR    = 7'b0100000,
        S_ACC    = 7'b1000000
    } t_state;

    // One window's statistics.
    typedef struct packed {
        logic [15:0] ref_sum;
        logic [15:0] cmp_sum;
        logic [31:0] ref_square_sum;
        logic [31:0] cmp_square_sum;
        logic [31:0] cross_sum;
        logic        last_window;
    } t_in_item;

    // One window's score and the running totals.
    typedef struct packed {
        logic signed [63:0] window_ssim;
        logic signed [63:0] ssim_total;
        logic signed [63:0] ssim_square_total;
        logic [31:0]        window_count;
        logic               is_last;
    } t_out_item;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: src/sswa_mul.sv
`default_nettype none

module sswa_mul
    import sswa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic signed [MUL_W-1:0] i_a,
    input  wire logic signed [MUL_W-1:0] i_b,
    output logic [63:0]                  o_prod
);

    logic signed [2*MUL_W-1:0] w_full;
    logic [63:0]               r_prod;

    // Signed product; unsigned operands arrive zero-extended by at least one bit.
    assign w_full = i_a * i_b;

    // The low 64 bits are registered before anything uses them.
    always_ff @(posedge i_clk) begin
        r_prod <= w_full[63:0];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: src/sswa_div.sv
`default_nettype none
`include "assert_macros.svh"

module sswa_div
    import sswa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic [DVD_W-1:0]      o_quot,
    output t_div_stat             o_stat
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_dvs;
    logic [DVD_W-1:0]     r_qd;

    logic [DEN_W:0]       w_shift;
    logic [DEN_W+1:0]     w_diff;
    logic                 w_ge;
    logic [DEN_W-1:0]     n_rem;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign w_shift = {r_rem, r_qd[DVD_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_diff[DEN_W+1];
    assign n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];

    // Control: busy for one step per dividend bit, then a one-cycle done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_LAST;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the dividend shifts out at the top while quotient bits
    // shift in at the bottom of the same register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_qd  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_qd  <= {r_qd[DVD_W-2:0], w_ge};
        end
    end

    assign o_quot      = r_qd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    // The partial remainder always stays below the divisor.
    `ASSERT_IMPL(a_rem_below_dvs, i_clk, i_rst_n, r_busy, r_rem < r_dvs)
    // A new division is only started once the previous one has finished.
    `ASSERT_IMPL(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)

endmodule

`default_nettype wire

FILE: src/ssim_window_score_accumulator.sv
// SSIM window score accumulator.
// Input channel: one request per window carries the two pixel sums, the two
// square sums, the cross sum and a last-window flag (i_in_valid, o_in_stall,
// i_in_data). Output channel: one request per window with the score, the
// running score and squared-score totals, the window count and the echoed
// flag (o_out_valid, i_out_stall, o_out_data).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0: C1, 1: C2, 2: window size); write only while no window is in flight.
// The block works on one window at a time: a sequence of products on one
// shared 33x33 multiplier, the 63-step restoring divider, then signing,
// squaring and accumulating the score, plus an idle state in which the
// next window is taken, so a new window is taken only after the previous
// one has been accumulated.
// The finished result waits in an output register, so the next window may
// enter while it is still stalled; a window only stalls in its final state
// if the previous result has not been taken yet.
// Reset (synchronous, active low) clears the totals and the window count,
// zeroes C1 and C2 and sets the window size to 8.
`default_nettype none
`include "assert_macros.svh"

module ssim_window_score_accumulator
    import sswa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;

    logic [31:0]         r_c1;
    logic [31:0]         r_c2;
    logic [WIN_W-1:0]    r_win;

    t_in_item            r_item;
    logic [WSQ_W-1:0]    r_wsq;
    logic [31:0]         r_mu_xy;
    logic [31:0]         r_mu_xx;
    logic [31:0]         r_mu_yy;
    logic [31:0]         r_p_rq;
    logic [31:0]         r_p_cq;
    logic [31:0]         r_p_xs;
    logic [31:0]         r_ta;
    logic [31:0]         r_tb;
    logic [31:0]         r_tc;
    logic [31:0]         r_td;
    logic [63:0]         r_num;
    logic [DEN_W-1:0]    r_den;
    logic [63:0]         r_sum_s;
    logic [DVD_W-1:0]    r_mag;
    logic                r_neg;
    logic [63:0]         r_score;
    logic [63:0]         r_sq_lo;
    logic [63:0]         r_sq;

    logic [63:0]         r_score_sum;
    logic [63:0]         r_score_sq_sum;
    logic [31:0]         r_count;
    t_out_item           r_out;
    logic                r_out_valid;

    logic signed [MUL_W-1:0] w_mul_a;
    logic signed [MUL_W-1:0] w_mul_b;
    logic [63:0]         w_prod;
    logic [DVD_W-1:0]    w_quot;
    t_div_stat           w_div_stat;
    logic                w_div_start;
    logic                w_in_take;
    logic                w_out_free;
    logic [31:0]         w_var_x;
    logic [31:0]         w_var_y;
    logic [31:0]         w_ta;
    logic [31:0]         w_tb;
    logic [31:0]         w_tc;
    logic [31:0]         w_td;
    logic [63:0]         w_neg_sum;
    logic [63:0]         w_quot_ext;
    logic [63:0]         n_score_sum;
    logic [63:0]         n_score_sq_sum;
    logic [31:0]         n_count;

    // Shared multiplier.
    sswa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Restoring divider.
    sswa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_den | DEN_W'(1)),
        .o_quot     (w_quot),
        .o_stat     (w_div_stat)
    );

    // Handshake helpers.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_take   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !(r_out_valid && i_out_stall);
    assign w_div_start = (r_state == S_DSTART);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1  <= '0;
            r_c2  <= '0;
            r_win <= WIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_C1:  r_c1  <= i_cfg_data;
                CFG_C2:  r_c2  <= i_cfg_data;
                CFG_WIN: r_win <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = S_PREP;
                    n_step  = ST_WSQ;
                end
            end
            S_PREP: begin
                if (r_step == ST_MAG) begin
                    n_state = S_DSTART;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_stat.done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_SQR;
                n_step  = SQ_LO;
            end
            S_SQR: begin
                if (r_step == SQ_X_CAP) begin
                    n_state = S_ACC;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ACC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Multiplier operand selection by state and step.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == S_PREP) begin
            case (r_step)
                ST_WSQ: begin
                    w_mul_a = {{(MUL_W-WIN_W){1'b0}}, r_win};
                    w_mul_b = {{(MUL_W-WIN_W){1'b0}}, r_win};
                end
                ST_MXY: begin
                    w_mul_a = {17'b0, r_item.ref_sum};
                    w_mul_b = {17'b0, r_item.cmp_sum};
                end
                ST_MXX: begin
                    w_mul_a = {17'b0, r_item.ref_sum};
                    w_mul_b = {17'b0, r_item.ref_sum};
                end
                ST_MYY: begin
                    w_mul_a = {17'b0, r_item.cmp_sum};
                    w_mul_b = {17'b0, r_item.cmp_sum};
                end
                ST_PRQ: begin
                    w_mul_a = {1'b0, r_item.ref_square_sum};
                    w_mul_b = {{(MUL_W-WSQ_W){1'b0}}, r_wsq};
                end
                ST_PCQ: begin
                    w_mul_a = {1'b0, r_item.cmp_square_sum};
                    w_mul_b = {{(MUL_W-WSQ_W){1'b0}}, r_wsq};
                end
                ST_PXS: begin
                    w_mul_a = {1'b0, r_item.cross_sum};
                    w_mul_b = {{(MUL_W-WSQ_W){1'b0}}, r_wsq};
                end
                ST_NUM: begin
                    w_mul_a = {r_ta[31], r_ta};
                    w_mul_b = {r_tb[31], r_tb};
                end
                ST_DEN: begin
                    w_mul_a = {r_tc[31], r_tc};
                    w_mul_b = {r_td[31], r_td};
                end
                default: ;
            endcase
        end else if (r_state == S_SQR) begin
            case (r_step)
                SQ_LO: begin
                    w_mul_a = {1'b0, r_score[31:0]};
                    w_mul_b = {1'b0, r_score[31:0]};
                end
                SQ_X: begin
                    w_mul_a = {1'b0, r_score[63:32]};
                    w_mul_b = {1'b0, r_score[31:0]};
                end
                default: ;
            endcase
        end
    end

    // SSIM terms; all of them wrap at 32 bits.
    always_comb begin
        w_var_x = r_p_rq - r_mu_xx;
        w_var_y = r_p_cq - r_mu_yy;
        w_ta    = r_mu_xy + (r_c1 >> 1);
        w_tb    = (r_p_xs >> 1) - (r_mu_xy >> 1) + (r_c2 >> 2);
        w_tc    = (r_mu_xx >> 1) + (r_mu_yy >> 1) + (r_c1 >> 1);
        w_td    = (w_var_x >> 1) + (w_var_y >> 1) + (r_c2 >> 1);
    end

    assign w_neg_sum  = ~r_sum_s + 64'd1;
    assign w_quot_ext = {{(64-DVD_W){1'b0}}, w_quot};

    // Working registers of one window.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item <= i_in_data;
        end
        if (r_state == S_PREP) begin
            case (r_step)
                ST_MXY:     r_wsq   <= w_prod[WSQ_W-1:0];
                ST_MXX:     r_mu_xy <= w_prod[31:0];
                ST_MYY:     r_mu_xx <= w_prod[31:0];
                ST_PRQ:     r_mu_yy <= w_prod[31:0];
                ST_PCQ:     r_p_rq  <= w_prod[31:0];
                ST_PXS:     r_p_cq  <= w_prod[31:0];
                ST_PXS_CAP: r_p_xs  <= w_prod[31:0];
                ST_TERMS: begin
                    r_ta <= w_ta;
                    r_tb <= w_tb;
                    r_tc <= w_tc;
                    r_td <= w_td;
                end
                ST_DEN:     r_num   <= w_prod;
                ST_DEN_CAP: r_den   <= w_prod[63:DEN_SHIFT];
                ST_SUM: begin
                    r_sum_s <= r_num + {{(DEN_SHIFT+1){1'b0}}, r_den[DEN_W-1:1]};
                end
                ST_MAG: begin
                    r_neg <= r_sum_s[63];
                    r_mag <= r_sum_s[63] ? w_neg_sum[DVD_W-1:0] : r_sum_s[DVD_W-1:0];
                end
                default: ;
            endcase
        end
        // Give the quotient back its sign.
        if (r_state == S_FIX) begin
            r_score <= r_neg ? (~w_quot_ext + 64'd1) : w_quot_ext;
        end
        // Low 64 bits of the square from two 32-bit partial products.
        if (r_state == S_SQR) begin
            case (r_step)
                SQ_LO_CAP: r_sq_lo <= w_prod;
                SQ_X_CAP:  r_sq    <= r_sq_lo + {w_prod[30:0], 33'b0};
                default: ;
            endcase
        end
    end

    // Running totals and the output register.
    assign n_score_sum    = r_score_sum + r_score;
    assign n_score_sq_sum = r_score_sq_sum + r_sq;
    assign n_count        = r_count + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_sum    <= '0;
            r_score_sq_sum <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else if ((r_state == S_ACC) && w_out_free) begin
            r_score_sum    <= n_score_sum;
            r_score_sq_sum <= n_score_sq_sum;
            r_count        <= n_count;
            r_out_valid    <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_ACC) && w_out_free) begin
            r_out.window_ssim       <= r_score;
            r_out.ssim_total        <= n_score_sum;
            r_out.ssim_square_total <= n_score_sq_sum;
            r_out.window_count      <= n_count;
            r_out.is_last           <= r_item.last_window;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The divider only works while the sequencer waits for it.
    `ASSERT_IMPL(a_div_in_wait, i_clk, i_rst_n, w_div_stat.busy || w_div_stat.done, r_state == S_DWAIT)
    // A finished window always lands in the output register and frees the block.
    `ASSERT_NEXT(a_acc_release, i_clk, i_rst_n, (r_state == S_ACC) && w_out_free, (r_state == S_IDLE) && r_out_valid)

endmodule

`default_nettype wire

FILE: tb/sv/ssim_score_checker.sv
`timescale 1ns / 100ps

module ssim_score_checker
    import sswa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_error_count,
    output int                   o_pending
);

    // Shadow copy of the configuration registers.
    logic [31:0]      c1_value;
    logic [31:0]      c2_value;
    logic [WIN_W-1:0] win_value;

    // Shadow copy of the running totals.
    logic [63:0] score_total;
    logic [63:0] square_total;
    logic [31:0] windows_seen;

    // Results still owed by the block, oldest first.
    t_out_item pending_scores[$];
    int        mismatches = 0;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    // Signed 32x32 product; each operand is taken as two's complement.
    function automatic logic signed [63:0] signed_mul32(input logic [31:0] a,
                                                        input logic [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = {{32{a[31]}}, a};
        wb = {{32{b[31]}}, b};
        return wa * wb;
    endfunction

    // Integer SSIM score of one window under the current configuration.
    function automatic logic signed [63:0] score_window(input t_in_item w);
        logic [31:0]        wsq;
        logic [31:0]        rs;
        logic [31:0]        cs;
        logic [31:0]        mu_xy;
        logic [31:0]        mu_xx;
        logic [31:0]        mu_yy;
        logic [31:0]        var_x;
        logic [31:0]        var_y;
        logic [31:0]        cov;
        logic [31:0]        ta;
        logic [31:0]        tb;
        logic [31:0]        tc;
        logic [31:0]        td;
        logic [63:0]        den_raw;
        logic signed [63:0] num;
        logic signed [63:0] dens;
        wsq   = 32'(win_value) * 32'(win_value);
        rs    = 32'(w.ref_sum);
        cs    = 32'(w.cmp_sum);
        mu_xy = rs * cs;
        mu_xx = rs * rs;
        mu_yy = cs * cs;
        var_x = w.ref_square_sum * wsq - mu_xx;
        var_y = w.cmp_square_sum * wsq - mu_yy;
        cov   = ((w.cross_sum * wsq) >> 1) - (mu_xy >> 1);
        ta    = mu_xy + (c1_value >> 1);
        tb    = cov + (c2_value >> 2);
        tc    = (mu_xx >> 1) + (mu_yy >> 1) + (c1_value >> 1);
        td    = (var_x >> 1) + (var_y >> 1) + (c2_value >> 1);
        num   = signed_mul32(ta, tb);
        // The denominator shift is logical on the raw 64-bit product.
        den_raw = signed_mul32(tc, td);
        den_raw = den_raw >> (SCALE_SHIFT + 1);
        dens    = den_raw;
        // Rounded division; the divisor is forced odd so it is never zero.
        return (num + (dens >>> 1)) / (dens | 64'sd1);
    endfunction

    // Track configuration, predict each accepted window and check results.
    always @(posedge i_clk) begin : track_windows
        t_out_item          want;
        logic signed [63:0] score;
        if (!i_rst_n) begin
            c1_value     = '0;
            c2_value     = '0;
            win_value    = WIN_RESET;
            score_total  = '0;
            square_total = '0;
            windows_seen = '0;
            pending_scores.delete();
        end else begin
            // Compare a delivered result with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (pending_scores.size() == 0) begin
                    $error("result delivered with no window outstanding");
                    mismatches++;
                end else begin
                    want = pending_scores.pop_front();
                    if (i_out_data.window_ssim !== want.window_ssim) begin
                        $error("window_ssim: expected %0d, got %0d",
                               want.window_ssim, i_out_data.window_ssim);
                        mismatches++;
                    end
                    if (i_out_data.ssim_total !== want.ssim_total) begin
                        $error("ssim_total: expected %0d, got %0d",
                               want.ssim_total, i_out_data.ssim_total);
                        mismatches++;
                    end
                    if (i_out_data.ssim_square_total !== want.ssim_square_total) begin
                        $error("ssim_square_total: expected %0d, got %0d",
                               want.ssim_square_total, i_out_data.ssim_square_total);
                        mismatches++;
                    end
                    if (i_out_data.window_count !== want.window_count) begin
                        $error("window_count: expected %0d, got %0d",
                               want.window_count, i_out_data.window_count);
                        mismatches++;
                    end
                    if (i_out_data.is_last !== want.is_last) begin
                        $error("is_last: expected %0d, got %0d",
                               want.is_last, i_out_data.is_last);
                        mismatches++;
                    end
                end
            end

            // Predict the result of an accepted window.
            if (i_in_valid && !i_in_stall) begin
                score         = score_window(i_in_data);
                score_total   = score_total + score;
                square_total  = square_total + score * score;
                windows_seen  = windows_seen + 32'd1;
                want.window_ssim       = score;
                want.ssim_total        = score_total;
                want.ssim_square_total = square_total;
                want.window_count      = windows_seen;
                want.is_last           = i_in_data.last_window;
                pending_scores.push_back(want);
            end

            // Register writes; an unknown index is ignored.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_C1: begin
                        c1_value = i_cfg_data;
                    end
                    CFG_C2: begin
                        c2_value = i_cfg_data;
                    end
                    CFG_WIN: begin
                        win_value = i_cfg_data[WIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_error_count <= mismatches;
        o_pending     <= pending_scores.size();
    end

endmodule

FILE: tb/sv/ssim_window_score_accumulator_tb.sv
`timescale 1ns / 100ps

module ssim_window_score_accumulator_tb;
    import sswa_pkg::*;

    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles without any accepted request before the run is abandoned.
    localparam int QUIET_LIMIT = 4000;

    localparam int RANDOM_PHASES   = 6;
    localparam int WINDOWS_PER_PHASE = 90;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int               error_count;
    int               pending;
    int               quiet_cycles = 0;
    int               burst_left   = 0;
    logic [WIN_W-1:0] current_win  = WIN_RESET;

    ssim_window_score_accumulator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ssim_score_checker score_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // 50 MHz clock.
    initial begin
        forever #10 clk = ~clk;
    end

    // The result side stalls in one of four modes, each picked anew at random.
    int   stall_mode = 0;
    int   stall_span = 0;
    int   stall_tick = 0;
    always @(posedge clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(100, 600);
        end else begin
            stall_span--;
        end
        stall_tick++;
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_stall <= stall_tick[5];
            end
        endcase
    end

    // Count cycles in which neither channel moves a request.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Corner values half the time, otherwise random bits.
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item window_of(input logic [15:0] rs, input logic [15:0] cs,
                                           input logic [31:0] rq, input logic [31:0] cq,
                                           input logic [31:0] xs, input logic last);
        t_in_item w;
        w.ref_sum        = rs;
        w.cmp_sum        = cs;
        w.ref_square_sum = rq;
        w.cmp_square_sum = cq;
        w.cross_sum      = xs;
        w.last_window    = last;
        return w;
    endfunction

    // Statistics with no relation between the fields.
    function automatic t_in_item noise_window();
        logic [31:0] rs;
        logic [31:0] cs;
        rs = pick32();
        cs = pick32();
        return window_of(rs[15:0], cs[15:0], pick32(), pick32(), pick32(),
                         ($urandom_range(0, 7) == 0));
    endfunction

    // Statistics of an actual pair of pixel windows.
    function automatic t_in_item pixel_window(input int edge_len, input int max_pixel);
        logic [31:0] rs;
        logic [31:0] cs;
        logic [31:0] rq;
        logic [31:0] cq;
        logic [31:0] xs;
        int          p;
        int          q;
        int          mode;
        int          base;
        rs   = '0;
        cs   = '0;
        rq   = '0;
        cq   = '0;
        xs   = '0;
        mode = $urandom_range(0, 4);
        base = $urandom_range(0, max_pixel);
        for (int i = 0; i < edge_len * edge_len; i++) begin
            p = (mode == 4) ? base : $urandom_range(0, max_pixel);
            case (mode)
                0: q = p;
                1: q = p + int'($urandom_range(0, 8)) - 4;
                2: q = $urandom_range(0, max_pixel);
                3: q = max_pixel - p;
                default: q = p;
            endcase
            if (q < 0) q = 0;
            if (q > max_pixel) q = max_pixel;
            rs = rs + p;
            cs = cs + q;
            rq = rq + p * p;
            cq = cq + q * q;
            xs = xs + p * q;
        end
        return window_of(rs[15:0], cs[15:0], rq, cq, xs, ($urandom_range(0, 7) == 0));
    endfunction

    // Offer one window and wait until it is taken; bursts end in a gap.
    task automatic send_window(input t_in_item item);
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(20, 150)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Wait until every predicted result has been delivered.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Consecutive writes keep the write enable high; it drops after the last.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] c1, input logic [31:0] c2,
                                  input logic [31:0] win_word);
        write_reg(CFG_C1, c1);
        write_reg(CFG_C2, c2);
        write_reg(CFG_WIN, win_word);
        write_reg(CFG_SPARE, $urandom());
        cfg_we      <= 1'b0;
        current_win = win_word[WIN_W-1:0];
        @(posedge clk);
    endtask

    // One well-formed window sized for the current setting, or noise.
    task automatic send_random_window();
        int edge_len;
        int max_pixel;
        if ($urandom_range(0, 3) == 0) begin
            send_window(noise_window());
        end else begin
            edge_len  = (current_win >= 1 && current_win <= 16) ? int'(current_win) : 8;
            max_pixel = (edge_len <= 8 && $urandom_range(0, 1) == 1) ? 1023 : 255;
            send_window(pixel_window(edge_len, max_pixel));
        end
    endtask

    initial begin : stimulus
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] win_word;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero constants can give a zero denominator.
        send_window(window_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0));
        send_window(window_of(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b1));
        send_window(window_of(16'hFFFF, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0));
        send_window(window_of(16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0));
        send_window(window_of(16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1));
        send_window(window_of(16'd8192, 16'd8192, 32'd1048576, 32'd1048576,
                              32'd1048576, 1'b0));
        send_window(window_of(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'hAAAA_AAAA, 1'b1));
        send_window(window_of(16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                              32'h5555_5555, 1'b0));
        drain_results();

        // Largest constants with the largest legal window.
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16);
        send_window(window_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1));
        send_window(window_of(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b0));
        send_window(pixel_window(16, 255));
        send_window(pixel_window(16, 255));
        drain_results();

        // A window size of zero removes the second-order sums.
        apply_settings(32'h0, 32'h0, 32'd0);
        send_window(window_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0));
        send_window(pixel_window(8, 1023));
        send_window(window_of(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b1));
        drain_results();

        // Out-of-range window size; upper data bits must be dropped.
        apply_settings(32'd1, 32'd3, 32'hFFFF_FFFF);
        send_window(pixel_window(8, 255));
        send_window(window_of(16'hFFFF, 16'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1'b0));
        send_window(noise_window());
        drain_results();

        // Random windows under a series of settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 3) begin
                c1 = $urandom_range(0, 1 << 20);
                c2 = $urandom_range(0, 1 << 22);
            end else begin
                c1 = pick32();
                c2 = pick32();
            end
            case (phase)
                0: win_word = 32'd8;
                1: win_word = 32'd1;
                2: win_word = 32'd16;
                3: win_word = 32'd0;
                4: win_word = ($urandom() & ~32'h1F) | $urandom_range(17, 31);
                default: win_word = $urandom();
            endcase
            apply_settings(c1, c2, win_word);
            repeat (WINDOWS_PER_PHASE) send_random_window();
            drain_results();
        end

        // Let any stray result show up before the verdict.
        repeat (100) @(posedge clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
